// File: rtl/kwl_pkg.sv
// ============================================================================
// kwl_pkg
// Shared constants, types and keyword table of the keyword token lexer
// ============================================================================
`default_nettype none

package kwl_pkg;

    // sizes of the token fields
    localparam int CODE_W = 6;
    localparam int LEN_W  = 8;
    localparam int CHAR_W = 8;

    // kept text and length limit
    localparam int KEPT_CHARS   = 8;
    localparam int LENGTH_LIMIT = 255;
    localparam int TEXT_BYTES   = (KEPT_CHARS < 8) ? KEPT_CHARS : 8;
    localparam int TEXT_W       = 8 * 8;
    localparam int TEXT_IDX_W   = $clog2(TEXT_BYTES);
    localparam logic [LEN_W-1:0] COUNT_CAP =
        LEN_W'((LENGTH_LIMIT > 255) ? 255 : LENGTH_LIMIT);

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // token class codes
    localparam logic [CODE_W-1:0] CODE_HASH   = 6'd0;
    localparam logic [CODE_W-1:0] CODE_IDENT  = 6'd25;
    localparam logic [CODE_W-1:0] CODE_NUMBER = 6'd26;
    localparam logic [CODE_W-1:0] CODE_PLUS   = 6'd27;
    localparam logic [CODE_W-1:0] CODE_MINUS  = 6'd28;
    localparam logic [CODE_W-1:0] CODE_STAR   = 6'd29;
    localparam logic [CODE_W-1:0] CODE_SLASH  = 6'd30;
    localparam logic [CODE_W-1:0] CODE_COLON  = 6'd31;
    localparam logic [CODE_W-1:0] CODE_ASSIGN = 6'd32;
    localparam logic [CODE_W-1:0] CODE_LT     = 6'd33;
    localparam logic [CODE_W-1:0] CODE_NE     = 6'd34;
    localparam logic [CODE_W-1:0] CODE_LE     = 6'd35;
    localparam logic [CODE_W-1:0] CODE_GT     = 6'd36;
    localparam logic [CODE_W-1:0] CODE_GE     = 6'd37;
    localparam logic [CODE_W-1:0] CODE_EQ     = 6'd38;
    localparam logic [CODE_W-1:0] CODE_SEMI   = 6'd41;
    localparam logic [CODE_W-1:0] CODE_LPAREN = 6'd42;
    localparam logic [CODE_W-1:0] CODE_RPAREN = 6'd43;

    // keyword table: text right aligned as written, length, class code
    localparam int NUM_KW = 25;

    localparam logic [63:0] KW_STR [NUM_KW] = '{
        64'("main"), 64'("if"), 64'("then"), 64'("while"), 64'("do"),
        64'("static"), 64'("default"), 64'("int"), 64'("double"),
        64'("struct"), 64'("break"), 64'("else"), 64'("long"),
        64'("switch"), 64'("case"), 64'("typedef"), 64'("char"),
        64'("return"), 64'("const"), 64'("float"), 64'("short"),
        64'("continue"), 64'("for"), 64'("void"), 64'("sizeof")
    };

    localparam logic [3:0] KW_LEN [NUM_KW] = '{
        4'd4, 4'd2, 4'd4, 4'd5, 4'd2, 4'd6, 4'd7, 4'd3, 4'd6, 4'd6, 4'd5,
        4'd4, 4'd4, 4'd6, 4'd4, 4'd7, 4'd4, 4'd6, 4'd5, 4'd5, 4'd5, 4'd8,
        4'd3, 4'd4, 4'd6
    };

    localparam logic [CODE_W-1:0] KW_CODE [NUM_KW] = '{
        6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd39, 6'd7, 6'd8, 6'd9, 6'd10,
        6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19,
        6'd20, 6'd21, 6'd22, 6'd23, 6'd24
    };

    // one result
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  length;
        logic [TEXT_W-1:0] text;
        logic              last;
    } token_t;

    // results of one scanned byte, handed to the result queue
    typedef struct packed {
        logic [1:0] count;
        token_t     first;
        token_t     second;
    } push_t;

    // parallel compare of a buffered word against all keywords
    function automatic logic [CODE_W-1:0] kw_lookup(
        input logic [TEXT_W-1:0] text,
        input logic [LEN_W-1:0]  count
    );
        logic [CODE_W-1:0] code;
        logic [TEXT_W-1:0] kw_text;
        int                l;
        code = CODE_IDENT;
        for (int k = 0; k < NUM_KW; k++)
        begin
            l = int'(KW_LEN[k]);
            kw_text = '0;
            for (int i = 0; i < 8; i++)
            begin
                if (i < l)
                begin
                    kw_text[8*i +: 8] = KW_STR[k][8*(l-1-i) +: 8];
                end
            end
            if ((count == LEN_W'(l)) && (text == kw_text))
            begin
                code = KW_CODE[k];
            end
        end
        return code;
    endfunction

endpackage

`default_nettype wire

// File: rtl/kwl_char_if.sv
// ============================================================================
// kwl_char_if
// Source byte channel: valid, ready and one byte
// ============================================================================
`default_nettype none

interface kwl_char_if
    import kwl_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

`default_nettype wire

// File: rtl/kwl_token_if.sv
// ============================================================================
// kwl_token_if
// Token channel: valid, ready and the fields of one token
// ============================================================================
`default_nettype none

interface kwl_token_if
    import kwl_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] token_code;
    logic [LEN_W-1:0]  token_length;
    logic [TEXT_W-1:0] token_text;
    logic              last_of_run;

    modport source (
        output valid, output token_code, output token_length,
        output token_text, output last_of_run, input ready
    );
    modport sink (
        input valid, input token_code, input token_length,
        input token_text, input last_of_run, output ready
    );
endinterface

`default_nettype wire

// File: rtl/kwl_scanner.sv
// ============================================================================
// kwl_scanner
// Byte register, scan state and single-pass token decode of one byte
// ============================================================================
`default_nettype none

module kwl_scanner
    import kwl_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    kwl_char_if.sink   char_chan,
    input  wire logic  space_ok,
    output push_t      push
);

    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_NL     = 8'd10;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    typedef enum logic [9:0] {
        M_IDLE       = 10'b00_0000_0001,
        M_IDENT      = 10'b00_0000_0010,
        M_NUMBER     = 10'b00_0000_0100,
        M_LT         = 10'b00_0000_1000,
        M_GT         = 10'b00_0001_0000,
        M_COLON      = 10'b00_0010_0000,
        M_SLASH      = 10'b00_0100_0000,
        M_LINE       = 10'b00_1000_0000,
        M_BLOCK      = 10'b01_0000_0000,
        M_BLOCK_STAR = 10'b10_0000_0000
    } mode_t;

    typedef struct packed {
        mode_t  mode;
        logic   emit;
        token_t tok;
        logic   start;
    } idle_res_t;

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic token_t make_tok(
        input logic [CODE_W-1:0] code,
        input logic [LEN_W-1:0]  len,
        input logic [TEXT_W-1:0] text
    );
        token_t t;
        t.code   = code;
        t.length = len;
        t.text   = text;
        t.last   = 1'b0;
        return t;
    endfunction

    // decode of a byte seen between tokens
    function automatic idle_res_t idle_scan(input logic [7:0] c, input logic word_start);
        idle_res_t r;
        r.mode  = M_IDLE;
        r.emit  = 1'b0;
        r.tok   = '0;
        r.start = 1'b0;
        if (is_letter(c))
        begin
            r.start = 1'b1;
            r.mode  = M_IDENT;
        end
        else if (is_digit(c))
        begin
            r.start = 1'b1;
            r.mode  = M_NUMBER;
        end
        else if (c == CH_LT)
        begin
            r.mode = M_LT;
        end
        else if (c == CH_GT)
        begin
            r.mode = M_GT;
        end
        else if (c == CH_COLON)
        begin
            r.mode = M_COLON;
        end
        else if (c == CH_SLASH)
        begin
            r.mode = M_SLASH;
        end
        else if (c == CH_HASH)
        begin
            r.emit = 1'b1;
            r.tok  = make_tok(CODE_HASH, LEN_W'(1), TEXT_W'(c));
            if (word_start)
            begin
                r.mode = M_LINE;
            end
        end
        else
        begin
            r.emit = 1'b1;
            r.tok  = make_tok(CODE_PLUS, LEN_W'(1), TEXT_W'(c));
            case (c)
                CH_PLUS:   r.tok.code = CODE_PLUS;
                CH_MINUS:  r.tok.code = CODE_MINUS;
                CH_STAR:   r.tok.code = CODE_STAR;
                CH_EQ:     r.tok.code = CODE_EQ;
                CH_SEMI:   r.tok.code = CODE_SEMI;
                CH_LPAREN: r.tok.code = CODE_LPAREN;
                CH_RPAREN: r.tok.code = CODE_RPAREN;
                default:   r.emit = 1'b0;
            endcase
        end
        return r;
    endfunction

    logic              in_valid_reg;
    logic [7:0]        char_reg;
    mode_t             mode_reg, mode_next;
    logic              word_start_reg, word_start_next;
    logic [TEXT_W-1:0] text_reg, text_next;
    logic [LEN_W-1:0]  count_reg, count_next;
    logic              over_reg, over_next;

    logic              fire;
    logic              emit_a, emit_b, use_idle, add_now, is_ws;
    token_t            tok_a;
    idle_res_t         idle_r;

    // byte register in front of the decode
    assign fire            = in_valid_reg && space_ok;
    assign char_chan.ready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (char_chan.valid && char_chan.ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_chan.valid && char_chan.ready)
        begin
            char_reg <= char_chan.char_in;
        end
    end

    // decode of the registered byte against the scan state
    always_comb
    begin
        mode_next  = mode_reg;
        text_next  = text_reg;
        count_next = count_reg;
        over_next  = over_reg;
        emit_a     = 1'b0;
        tok_a      = '0;
        use_idle   = 1'b0;
        add_now    = 1'b0;
        idle_r     = idle_scan(char_reg, word_start_reg);
        is_ws      = (char_reg == CH_SPACE) || (char_reg == CH_TAB) || (char_reg == CH_NL);
        word_start_next = is_ws;

        unique case (mode_reg)
            M_LINE:
            begin
                if (char_reg == CH_NL)
                begin
                    mode_next = M_IDLE;
                end
            end
            M_BLOCK:
            begin
                if (char_reg == CH_STAR)
                begin
                    mode_next = M_BLOCK_STAR;
                end
            end
            M_BLOCK_STAR:
            begin
                if (char_reg == CH_SLASH)
                begin
                    mode_next = M_IDLE;
                end
                else if (char_reg != CH_STAR)
                begin
                    mode_next = M_BLOCK;
                end
            end
            M_IDENT:
            begin
                if (is_letter(char_reg) || is_digit(char_reg) || (char_reg == CH_UNDER))
                begin
                    add_now = 1'b1;
                end
                else
                begin
                    emit_a   = 1'b1;
                    tok_a    = make_tok((over_reg || (count_reg > LEN_W'(8))) ?
                                        CODE_IDENT : kw_lookup(text_reg, count_reg),
                                        count_reg, text_reg);
                    use_idle = 1'b1;
                end
            end
            M_NUMBER:
            begin
                if (is_digit(char_reg))
                begin
                    add_now = 1'b1;
                end
                else
                begin
                    emit_a   = 1'b1;
                    tok_a    = make_tok(CODE_NUMBER, count_reg, text_reg);
                    use_idle = 1'b1;
                end
            end
            M_LT:
            begin
                emit_a = 1'b1;
                if (char_reg == CH_EQ)
                begin
                    tok_a     = make_tok(CODE_LE, LEN_W'(2), TEXT_W'(16'h3D3C));
                    mode_next = M_IDLE;
                end
                else if (char_reg == CH_GT)
                begin
                    tok_a     = make_tok(CODE_NE, LEN_W'(2), TEXT_W'(16'h3E3C));
                    mode_next = M_IDLE;
                end
                else
                begin
                    tok_a    = make_tok(CODE_LT, LEN_W'(1), TEXT_W'(CH_LT));
                    use_idle = 1'b1;
                end
            end
            M_GT:
            begin
                emit_a = 1'b1;
                if (char_reg == CH_EQ)
                begin
                    tok_a     = make_tok(CODE_GE, LEN_W'(2), TEXT_W'(16'h3D3E));
                    mode_next = M_IDLE;
                end
                else
                begin
                    tok_a    = make_tok(CODE_GT, LEN_W'(1), TEXT_W'(CH_GT));
                    use_idle = 1'b1;
                end
            end
            M_COLON:
            begin
                emit_a = 1'b1;
                if (char_reg == CH_EQ)
                begin
                    tok_a     = make_tok(CODE_ASSIGN, LEN_W'(2), TEXT_W'(16'h3D3A));
                    mode_next = M_IDLE;
                end
                else
                begin
                    tok_a    = make_tok(CODE_COLON, LEN_W'(1), TEXT_W'(CH_COLON));
                    use_idle = 1'b1;
                end
            end
            M_SLASH:
            begin
                if (char_reg == CH_SLASH)
                begin
                    mode_next = M_LINE;
                end
                else if (char_reg == CH_STAR)
                begin
                    mode_next = M_BLOCK;
                end
                else
                begin
                    emit_a   = 1'b1;
                    tok_a    = make_tok(CODE_SLASH, LEN_W'(1), TEXT_W'(CH_SLASH));
                    use_idle = 1'b1;
                end
            end
            M_IDLE:
            begin
                use_idle = 1'b1;
            end
            default:
            begin
                use_idle = 1'b1;
            end
        endcase

        // byte read as between tokens, which may start a new token
        if (use_idle)
        begin
            mode_next = idle_r.mode;
            if (idle_r.start)
            begin
                text_next  = TEXT_W'(char_reg);
                count_next = LEN_W'(1);
                over_next  = 1'b0;
            end
        end

        // byte appended to the current word
        if (add_now)
        begin
            if (count_reg < COUNT_CAP)
            begin
                if (count_reg < LEN_W'(TEXT_BYTES))
                begin
                    text_next[8*count_reg[TEXT_IDX_W-1:0] +: 8] = char_reg;
                end
                count_next = count_reg + LEN_W'(1);
            end
            else
            begin
                over_next = 1'b1;
            end
        end

        emit_b = use_idle && idle_r.emit;

        // results in order, last one flagged
        push.first  = emit_a ? tok_a : idle_r.tok;
        push.second = idle_r.tok;
        push.first.last  = !(emit_a && emit_b);
        push.second.last = 1'b1;
        if (fire)
        begin
            push.count = {1'b0, emit_a} + {1'b0, emit_b};
        end
        else
        begin
            push.count = 2'd0;
        end
    end

    // scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= M_IDLE;
            word_start_reg <= 1'b1;
            text_reg       <= '0;
            count_reg      <= '0;
            over_reg       <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg       <= mode_next;
            word_start_reg <= word_start_next;
            text_reg       <= text_next;
            count_reg      <= count_next;
            over_reg       <= over_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/kwl_token_fifo.sv
// ============================================================================
// kwl_token_fifo
// Small result queue: takes up to two tokens a cycle, hands out one
// ============================================================================
`default_nettype none

module kwl_token_fifo
    import kwl_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  push_t       push,
    output logic        space_ok,
    kwl_token_if.source token_chan
);

    token_t               entries [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   rd_ptr_reg, wr_ptr_reg;
    logic [FIFO_CW-1:0]   count_reg;
    logic                 pop;
    token_t               head;

    // room for the worst case of one byte
    assign space_ok = (count_reg <= FIFO_CW'(FIFO_DEPTH - 2));

    // head entry drives the channel
    assign head                   = entries[rd_ptr_reg];
    assign token_chan.valid        = (count_reg != '0);
    assign token_chan.token_code   = head.code;
    assign token_chan.token_length = head.length;
    assign token_chan.token_text   = head.text;
    assign token_chan.last_of_run  = head.last;
    assign pop = token_chan.valid && token_chan.ready;

    // entry writes
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entries[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            entries[wr_ptr_reg + FIFO_AW'(1)] <= push.second;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(push.count);
            rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(pop);
            count_reg  <= count_reg + FIFO_CW'(push.count) - FIFO_CW'(pop);
        end
    end

    // checks
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CW'(FIFO_DEPTH))
        else $error("result queue over its depth");

    a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> space_ok)
        else $error("tokens pushed without room");

    a_push_at_most_two: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd3)
        else $error("more than two tokens from one byte");

    a_ptr_level: assert property (@(posedge clk) disable iff (!rst_n)
        FIFO_AW'(wr_ptr_reg - rd_ptr_reg) == count_reg[FIFO_AW-1:0])
        else $error("queue pointers disagree with fill level");

endmodule

`default_nettype wire

// File: rtl/keyword_token_lexer.sv
// ============================================================================
// keyword_token_lexer
// Byte-serial lexer: source bytes in, token codes with length and text out
// ============================================================================
// One source byte is taken per cycle into a byte register while the queue
// has room; the decode then reads it against the scan state in a single pass
// (keyword compare is a parallel match against the constant table) and writes
// the zero, one or two tokens it ends into a four-entry result queue that
// drives the token channel. A byte is taken while the queue has at least two
// free slots, so with the token side always ready the block runs at one byte
// per cycle; a byte that ends two tokens has them handed out one after the
// other on the token side, and a stalled token side holds the byte side once
// the queue fills.
`default_nettype none

module keyword_token_lexer
    import kwl_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    kwl_char_if.sink    char_chan,
    kwl_token_if.source token_chan
);

    push_t push;
    logic  space_ok;

    // byte decode and scan state
    kwl_scanner u_scanner (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_chan (char_chan),
        .space_ok  (space_ok),
        .push      (push)
    );

    // result queue
    kwl_token_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .space_ok   (space_ok),
        .token_chan (token_chan)
    );

endmodule

`default_nettype wire
